@@ hw/rtl/vtfa_pkg.sv @@
// ----------------------------------------------------------------------------
// vtfa_pkg
// Shared types and constants of the vertex tangent frame averager.
// ----------------------------------------------------------------------------
`default_nettype none

package vtfa_pkg;

    localparam int VERTEX_COUNT   = 1024;
    localparam int COMPONENT_BITS = 16;
    localparam int INDEX_BITS     = 10;
    localparam int ONE_SHIFT      = COMPONENT_BITS - 2;
    localparam int SUM_BITS       = COMPONENT_BITS + 2;
    localparam int MAG_BITS       = SUM_BITS;
    localparam int L2_BITS        = 2 * MAG_BITS + 2;
    localparam int Q_BITS         = COMPONENT_BITS - 1;
    localparam int QCNT_BITS      = 4;
    localparam int ENTRY_BITS     = 3 * COMPONENT_BITS;
    localparam int REDUCE_SHIFT   = 17;

    localparam logic [1:0] CMD_ACCUM = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;
    localparam logic [1:0] ST_READ    = 2'd3;

    typedef logic signed [COMPONENT_BITS-1:0] t_comp;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [INDEX_BITS-1:0] vertex_index;
        logic                  fetch_ok;
        t_comp                 tan_x;
        t_comp                 tan_y;
        t_comp                 tan_z;
        t_comp                 bin_x;
        t_comp                 bin_y;
        t_comp                 bin_z;
    } t_in;

    typedef struct packed {
        logic [INDEX_BITS-1:0] out_index;
        t_comp                 avg_tan_x;
        t_comp                 avg_tan_y;
        t_comp                 avg_tan_z;
        t_comp                 avg_bin_x;
        t_comp                 avg_bin_y;
        t_comp                 avg_bin_z;
        logic [1:0]            status;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic       latch_in;
        logic       mem_rd;
        logic       load_entry;
        logic       sel_bin;
        logic       calc_sum;
        logic       calc_sq;
        logic       calc_l2;
        logic       bs_init;
        logic       bs_mid;
        logic       bs_mul;
        logic       bs_step;
        logic [1:0] comp_sel;
        logic       bs_store;
        logic       mem_wr;
        logic       clr_wr;
        logic       clr_next;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_zero;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       fetch_ok;
        logic       in_range;
        logic       clr_last;
        logic       bs_done;
    } t_stat;

endpackage

`default_nettype wire

@@ hw/rtl/vtfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// vtfa_ctrl
// Sequencer: decodes the command and steps the datapath through its phases.
// ----------------------------------------------------------------------------
`default_nettype none

module vtfa_ctrl
    import vtfa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    output logic       o_busy,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_SQ     = 4'd5;
    localparam logic [3:0] S_L2     = 4'd6;
    localparam logic [3:0] S_BINIT  = 4'd7;
    localparam logic [3:0] S_BMID   = 4'd8;
    localparam logic [3:0] S_BMUL   = 4'd9;
    localparam logic [3:0] S_BCMP   = 4'd10;
    localparam logic [3:0] S_WR     = 4'd11;
    localparam logic [3:0] S_CLR    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;
    localparam logic [3:0] S_INIT   = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_bin, n_bin;
    logic [1:0] r_comp, n_comp;
    logic [1:0] r_status, n_status;
    logic       r_zero, n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_bin    <= 1'b0;
            r_comp   <= 2'd0;
            r_status <= ST_UPDATED;
            r_zero   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bin    <= n_bin;
            r_comp   <= n_comp;
            r_status <= n_status;
            r_zero   <= n_zero;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_comp   = r_comp;
        n_status = r_status;
        n_zero   = r_zero;
        o_ctrl   = '0;
        o_ctrl.sel_bin    = r_bin;
        o_ctrl.comp_sel   = r_comp;
        o_ctrl.out_status = r_status;
        o_ctrl.out_zero   = r_zero;
        unique case (r_state)
            S_INIT: begin
                o_ctrl.clr_wr   = 1'b1;
                o_ctrl.clr_next = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.latch_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_bin  = 1'b0;
                n_comp = 2'd0;
                n_zero = !i_stat.in_range;
                if (i_stat.cmd == CMD_CLEAR) begin
                    n_status = ST_CLEARED;
                    n_zero   = 1'b1;
                    n_state  = S_CLR;
                end else if (i_stat.cmd == CMD_ACCUM && i_stat.fetch_ok
                             && i_stat.in_range) begin
                    n_status = ST_UPDATED;
                    n_state  = S_RD;
                end else begin
                    n_status = (i_stat.cmd == CMD_ACCUM) ? ST_SKIPPED : ST_READ;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                o_ctrl.mem_rd = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_ctrl.load_entry = 1'b1;
                n_state = (r_status == ST_UPDATED) ? S_SUM : S_OUT;
            end
            S_SUM: begin
                o_ctrl.calc_sum = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_ctrl.calc_sq = 1'b1;
                n_state = S_L2;
            end
            S_L2: begin
                o_ctrl.calc_l2 = 1'b1;
                n_comp  = 2'd0;
                n_state = S_BINIT;
            end
            S_BINIT: begin
                o_ctrl.bs_init = 1'b1;
                n_state = S_BMID;
            end
            S_BMID: begin
                if (i_stat.bs_done) begin
                    o_ctrl.bs_store = 1'b1;
                    if (r_comp == 2'd2) begin
                        if (r_bin) begin
                            n_state = S_WR;
                        end else begin
                            n_bin   = 1'b1;
                            n_state = S_SUM;
                        end
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = S_BINIT;
                    end
                end else begin
                    o_ctrl.bs_mid = 1'b1;
                    n_state = S_BMUL;
                end
            end
            S_BMUL: begin
                o_ctrl.bs_mul = 1'b1;
                n_state = S_BCMP;
            end
            S_BCMP: begin
                o_ctrl.bs_step = 1'b1;
                n_state = S_BMID;
            end
            S_WR: begin
                o_ctrl.mem_wr = 1'b1;
                n_state = S_OUT;
            end
            S_CLR: begin
                o_ctrl.clr_wr   = 1'b1;
                o_ctrl.clr_next = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_ctrl.out_load = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/vtfa_datapath.sv @@
// ----------------------------------------------------------------------------
// vtfa_datapath
// Tables, sum and square logic, and the shared bisection unit for scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module vtfa_datapath
    import vtfa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_in   i_in,
    input  wire t_ctrl i_ctrl,
    output t_stat      o_stat,
    output t_out       o_out
);

    localparam int CLR_BITS = INDEX_BITS + 1;
    localparam int PROD_BITS = 2 * L2_BITS + 4;
    localparam int TT_BITS = 2 * Q_BITS + 4;
    localparam int L2_HALF = L2_BITS / 2;
    localparam int PP_BITS = TT_BITS + L2_BITS - L2_HALF;

    logic [ENTRY_BITS-1:0] r_tan_mem [VERTEX_COUNT];
    logic [ENTRY_BITS-1:0] r_bin_mem [VERTEX_COUNT];

    t_in                   r_in;
    logic [ENTRY_BITS-1:0] r_rd_tan, r_rd_bin;
    t_comp                 r_old [2][3];
    t_comp                 r_res [2][3];
    logic [MAG_BITS-1:0]   r_mag [3];
    logic                  r_neg [3];
    logic [2*MAG_BITS-1:0] r_sq [3];
    logic [L2_BITS-1:0]    r_l2;
    logic [Q_BITS:0]       r_lo, r_hi;
    logic [Q_BITS:0]       r_mid;
    logic [TT_BITS-1:0]    r_tt;
    logic [PP_BITS-1:0]    r_p_lo, r_p_hi;
    logic [CLR_BITS-1:0]   r_clr;
    t_out                  r_out;

    logic                  in_range;
    t_comp                 add_c [3];
    logic signed [SUM_BITS-1:0] s [3];
    logic [SUM_BITS-1:0]   m [3];
    logic                  big;
    logic [Q_BITS:0]       mid;
    logic [Q_BITS+1:0]     t;
    logic [TT_BITS-1:0]    tt;
    logic [PROD_BITS-1:0]  lhs, rhs;
    logic [2*MAG_BITS-1:0] msq;
    logic                  le;

    assign in_range = ({1'b0, r_in.vertex_index} < (CLR_BITS)'(VERTEX_COUNT));

    always_comb begin
        add_c[0] = i_ctrl.sel_bin ? r_in.bin_x : r_in.tan_x;
        add_c[1] = i_ctrl.sel_bin ? r_in.bin_y : r_in.tan_y;
        add_c[2] = i_ctrl.sel_bin ? r_in.bin_z : r_in.tan_z;
        big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            s[i] = SUM_BITS'(r_old[i_ctrl.sel_bin][i]) + SUM_BITS'(add_c[i]);
            m[i] = s[i][SUM_BITS-1] ? SUM_BITS'(-s[i]) : SUM_BITS'(s[i]);
            if (m[i] >= SUM_BITS'(1 << REDUCE_SHIFT)) begin
                big = 1'b1;
            end
        end
    end

    always_comb begin
        mid = r_lo + ((r_hi - r_lo + (Q_BITS+1)'(1)) >> 1);
        t   = {mid, 1'b0} - (Q_BITS+2)'(1);
        tt  = TT_BITS'(t) * TT_BITS'(t);
        msq = r_sq[i_ctrl.comp_sel];
        lhs = (PROD_BITS'(r_p_hi) << L2_HALF) + PROD_BITS'(r_p_lo);
        rhs = PROD_BITS'(msq) << (2 * ONE_SHIFT + 2);
        le  = (lhs <= rhs);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch_in) begin
            r_in <= i_in;
        end
        if (i_ctrl.mem_rd) begin
            r_rd_tan <= r_tan_mem[r_in.vertex_index];
            r_rd_bin <= r_bin_mem[r_in.vertex_index];
        end
        if (i_ctrl.load_entry) begin
            for (int i = 0; i < 3; i++) begin
                r_old[0][i] <= r_rd_tan[i*COMPONENT_BITS +: COMPONENT_BITS];
                r_old[1][i] <= r_rd_bin[i*COMPONENT_BITS +: COMPONENT_BITS];
                r_res[0][i] <= r_rd_tan[i*COMPONENT_BITS +: COMPONENT_BITS];
                r_res[1][i] <= r_rd_bin[i*COMPONENT_BITS +: COMPONENT_BITS];
            end
        end
        if (i_ctrl.calc_sum) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= big ? (m[i] >> 1) : m[i];
                r_neg[i] <= s[i][SUM_BITS-1];
            end
        end
        if (i_ctrl.calc_sq) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*MAG_BITS)'(r_mag[i]) * (2*MAG_BITS)'(r_mag[i]);
            end
        end
        if (i_ctrl.calc_l2) begin
            r_l2 <= L2_BITS'(r_sq[0]) + L2_BITS'(r_sq[1]) + L2_BITS'(r_sq[2]);
        end
        if (i_ctrl.bs_mid) begin
            r_mid <= mid;
            r_tt  <= tt;
        end
        if (i_ctrl.bs_mul) begin
            r_p_lo <= PP_BITS'(r_tt) * PP_BITS'(r_l2[L2_HALF-1:0]);
            r_p_hi <= PP_BITS'(r_tt) * PP_BITS'(r_l2[L2_BITS-1:L2_HALF]);
        end
        if (i_ctrl.bs_init) begin
            r_lo <= '0;
            r_hi <= (Q_BITS+1)'(1 << ONE_SHIFT);
        end else if (i_ctrl.bs_step && r_lo < r_hi) begin
            if (le) begin
                r_lo <= r_mid;
            end else begin
                r_hi <= r_mid - (Q_BITS+1)'(1);
            end
        end
        if (i_ctrl.bs_store) begin
            r_res[i_ctrl.sel_bin][i_ctrl.comp_sel] <= (r_l2 == '0) ? '0 :
                (r_neg[i_ctrl.comp_sel] ? -COMPONENT_BITS'(r_lo) : COMPONENT_BITS'(r_lo));
        end
        if (i_ctrl.mem_wr) begin
            r_tan_mem[r_in.vertex_index] <= {r_res[0][2], r_res[0][1], r_res[0][0]};
            r_bin_mem[r_in.vertex_index] <= {r_res[1][2], r_res[1][1], r_res[1][0]};
        end else if (i_ctrl.clr_wr) begin
            r_tan_mem[r_clr[INDEX_BITS-1:0]] <= '0;
            r_bin_mem[r_clr[INDEX_BITS-1:0]] <= '0;
        end
        if (i_ctrl.out_load) begin
            r_out.out_index <= r_in.vertex_index;
            r_out.status    <= i_ctrl.out_status;
            r_out.avg_tan_x <= i_ctrl.out_zero ? '0 : r_res[0][0];
            r_out.avg_tan_y <= i_ctrl.out_zero ? '0 : r_res[0][1];
            r_out.avg_tan_z <= i_ctrl.out_zero ? '0 : r_res[0][2];
            r_out.avg_bin_x <= i_ctrl.out_zero ? '0 : r_res[1][0];
            r_out.avg_bin_y <= i_ctrl.out_zero ? '0 : r_res[1][1];
            r_out.avg_bin_z <= i_ctrl.out_zero ? '0 : r_res[1][2];
        end
    end

    // clear sweep pointer and the reset sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.latch_in) begin
            r_clr <= '0;
        end else if (i_ctrl.clr_next) begin
            r_clr <= r_clr + CLR_BITS'(1);
        end
    end

    assign o_stat.cmd      = r_in.cmd;
    assign o_stat.fetch_ok = r_in.fetch_ok;
    assign o_stat.in_range = in_range;
    assign o_stat.clr_last = (r_clr == CLR_BITS'(VERTEX_COUNT - 1));
    assign o_stat.bs_done  = !(r_lo < r_hi);
    assign o_out           = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/vertex_tangent_frame_averager.sv @@
// ----------------------------------------------------------------------------
// vertex_tangent_frame_averager
// Per-vertex tangent/binormal table with averaging and unit normalization.
//
// Channel  Direction  Handshake
// input    in         start, accepted when busy low
// result   out        o_done strobe, one cycle, one result per transaction
//
// Accumulate: each of six components is scaled by a bisection of 14 or 15
// steps, each step passing through the mid, multiply and compare states.
// Read and skip: table read, then result without scaling. Clear: both tables zeroed.
// After reset, busy stays high while both tables are zeroed.
// The receiver cannot stall; busy holds off new transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_tangent_frame_averager
    import vtfa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_in  i_in,
    output logic      o_done,
    output t_out      o_out
);

    t_ctrl ctrl;
    t_stat stat;

    vtfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    vtfa_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .o_out   (o_out)
    );

    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ctrl.out_load;
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire
